[design/wscd_pkg.sv]
package wscd_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_24   = 2'd1,
    KIND_5    = 2'd2,
    KIND_6    = 2'd3
  } band_kind_t;

  localparam logic [1:0] REG_ROW_A_FIRST  = 2'd0;
  localparam logic [1:0] REG_CODE_BAND_24 = 2'd1;
  localparam logic [1:0] REG_CODE_BAND_5  = 2'd2;
  localparam logic [1:0] REG_CODE_BAND_6  = 2'd3;

  localparam logic [31:0] MASK_A_24 = 32'h0000_3FFF;
  localparam logic [31:0] MASK_A_5  = 32'h01FF_FFFF;
  localparam logic [31:0] MASK_A_6  = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_B_6  = 32'h07FF_FFFF;

  localparam logic [12:0] MHZ_CH14 = 13'd2484;
  localparam logic [12:0] MHZ_24   = 13'd2407;
  localparam logic [12:0] MHZ_5    = 13'd5000;
  localparam logic [12:0] MHZ_6    = 13'd5950;

  typedef struct packed {
    logic        row_a_first;
    logic [15:0] code_band_24;
    logic [15:0] code_band_5;
    logic [15:0] code_band_6;
  } cfg_t;

  typedef struct packed {
    band_kind_t  kind;
    logic [63:0] mask;
    logic        valid;
    logic        empty;
    logic [63:0] norm;
    logic        moved;
    logic [7:0]  band_lo;
    logic [5:0]  count;
    logic [5:0]  first_idx;
  } item_t;

  // Bit index: bit 5 selects row B, bits 4:0 are the bit within the row.
  function automatic logic [7:0] bit_channel(band_kind_t kind, logic [5:0] idx);
    logic [4:0] b;
    logic [7:0] b4;
    logic [7:0] ch;
    b  = idx[4:0];
    b4 = {1'b0, b, 2'b00};
    ch = 8'd0;
    case (kind)
      KIND_24: begin
        if (!idx[5] && b <= 5'd13) ch = {3'd0, b} + 8'd1;
      end
      KIND_5: begin
        if (!idx[5]) begin
          if (b <= 5'd7) ch = 8'd36 + b4;
          else if (b <= 5'd19) ch = 8'd68 + b4;
          else if (b <= 5'd24) ch = 8'd69 + b4;
        end
      end
      KIND_6: begin
        if (!idx[5]) ch = 8'd1 + b4;
        else if (b <= 5'd26) ch = 8'd129 + b4;
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [12:0] chan_mhz(band_kind_t kind, logic [7:0] ch);
    logic [12:0] c;
    logic [12:0] c5;
    logic [12:0] mhz;
    c   = {5'd0, ch};
    c5  = (c << 2) + c;
    mhz = 13'd0;
    case (kind)
      KIND_24: mhz = (ch == 8'd14) ? MHZ_CH14 : MHZ_24 + c5;
      KIND_5:  mhz = MHZ_5 + c5;
      KIND_6:  mhz = MHZ_6 + c5;
      default: mhz = 13'd0;
    endcase
    return mhz;
  endfunction

endpackage

[design/wscd_front.sv]
module wscd_front import wscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] band_code,
  input  logic [63:0] channel_bitmap,
  output logic        push,
  output item_t       push_item,
  input  logic        full
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_COUNT = 3'b010,
    F_PUSH  = 3'b100
  } front_state_t;

  front_state_t state;
  item_t        cur;
  logic [2:0]   chunk;
  logic         found;

  band_kind_t  kind;
  logic [31:0] wa;
  logic [31:0] wb;
  logic [31:0] assign_a;
  logic [31:0] assign_b;
  logic        empty;
  logic        moved;
  logic        accept;

  logic [7:0] chunk_bits;
  logic [3:0] chunk_pop;
  logic [2:0] chunk_first;
  logic       chunk_any;

  assign accept = start && (state == F_IDLE);
  assign busy   = (state != F_IDLE);
  assign push   = (state == F_PUSH) && !full;
  assign push_item = cur;

  always_comb begin
    if (band_code == cfg.code_band_24) kind = KIND_24;
    else if (band_code == cfg.code_band_5) kind = KIND_5;
    else if (band_code == cfg.code_band_6) kind = KIND_6;
    else kind = KIND_NONE;
  end

  assign wa    = cfg.row_a_first ? channel_bitmap[63:32] : channel_bitmap[31:0];
  assign wb    = cfg.row_a_first ? channel_bitmap[31:0] : channel_bitmap[63:32];
  assign empty = (channel_bitmap == 64'd0);
  assign moved = (kind == KIND_24 || kind == KIND_5) && (wa == 32'd0) && (wb != 32'd0);

  always_comb begin
    case (kind)
      KIND_24: begin
        assign_a = MASK_A_24;
        assign_b = 32'd0;
      end
      KIND_5: begin
        assign_a = MASK_A_5;
        assign_b = 32'd0;
      end
      KIND_6: begin
        assign_a = MASK_A_6;
        assign_b = MASK_B_6;
      end
      default: begin
        assign_a = 32'd0;
        assign_b = 32'd0;
      end
    endcase
  end

  assign chunk_bits = cur.mask[{chunk, 3'b000} +: 8];

  always_comb begin
    chunk_pop   = 4'd0;
    chunk_first = 3'd0;
    for (int i = 0; i < 8; i++) begin
      chunk_pop = chunk_pop + {3'd0, chunk_bits[i]};
    end
    for (int i = 7; i >= 0; i--) begin
      if (chunk_bits[i]) chunk_first = 3'(i);
    end
    chunk_any = (chunk_bits != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      chunk <= 3'd0;
      found <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_COUNT;
            chunk <= 3'd0;
            found <= 1'b0;
          end
        end
        F_COUNT: begin
          if (!found && chunk_any) found <= 1'b1;
          chunk <= chunk + 3'd1;
          if (chunk == 3'd7) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.kind      <= kind;
      cur.mask      <= {(empty ? assign_b : (wb & assign_b)),
                        (empty ? assign_a : (wa & assign_a))};
      cur.valid     <= (kind == KIND_NONE) ? empty
                     : (((wa & ~assign_a) == 32'd0) && ((wb & ~assign_b) == 32'd0));
      cur.empty     <= empty;
      cur.moved     <= moved;
      cur.norm      <= !moved ? channel_bitmap
                     : (cfg.row_a_first ? {wb, 32'd0} : {32'd0, wb});
      cur.band_lo   <= band_code[7:0];
      cur.count     <= 6'd0;
      cur.first_idx <= 6'd0;
    end else if (state == F_COUNT) begin
      cur.count <= cur.count + {2'd0, chunk_pop};
      if (!found && chunk_any) cur.first_idx <= {chunk, chunk_first};
    end
  end

endmodule

[design/wscd_queue.sv]
module wscd_queue import wscd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/wscd_back.sv]
module wscd_back import wscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        pop,
  output logic        result_strobe,
  output logic [7:0]  channel,
  output logic [12:0] channel_mhz,
  output logic        is_last,
  output logic        no_channel,
  output logic        list_valid,
  output logic        all_channels,
  output logic [5:0]  channel_count,
  output logic [12:0] first_mhz,
  output logic [15:0] first_chan_field,
  output logic [63:0] normalized_list,
  output logic        rows_moved
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_t;

  back_state_t state;
  item_t       item;
  logic [5:0]  idx;
  logic [5:0]  remaining;

  logic       none_case;
  logic       hit;
  logic       emit;
  logic       last;
  logic [7:0] cur_ch;
  logic [7:0] first_ch;
  logic       show_first;

  assign pop        = (state == B_IDLE) && !q_empty;
  assign none_case  = (item.count == 6'd0);
  assign hit        = item.mask[idx];
  assign emit       = (state == B_RUN) && (none_case || hit);
  assign last       = none_case || (remaining == 6'd1);
  assign cur_ch     = bit_channel(item.kind, idx);
  assign first_ch   = bit_channel(item.kind, item.first_idx);
  assign show_first = !item.empty && !none_case;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      idx           <= 6'd0;
      remaining     <= 6'd0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state     <= B_RUN;
            idx       <= 6'd0;
            remaining <= q_item.count;
          end
        end
        B_RUN: begin
          idx <= idx + 6'd1;
          if (emit) begin
            if (!none_case) remaining <= remaining - 6'd1;
            if (last) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item <= q_item;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel          <= none_case ? 8'd0 : cur_ch;
      channel_mhz      <= none_case ? 13'd0 : chan_mhz(item.kind, cur_ch);
      is_last          <= last;
      no_channel       <= none_case;
      list_valid       <= item.valid;
      all_channels     <= item.empty;
      channel_count    <= item.count;
      first_mhz        <= show_first ? chan_mhz(item.kind, first_ch) : 13'd0;
      first_chan_field <= show_first ? {item.band_lo, first_ch} : 16'd0;
      normalized_list  <= item.norm;
      rows_moved       <= item.moved;
    end
  end

endmodule

[design/wlan_scan_channel_list_decode_unit.sv]
// Scan channel list decoder.
// A transaction on the command side is taken at a rising edge where start is
// high and busy is low; it carries band_code and the 8-byte channel_bitmap.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, one register per cycle. The user must write them only while no
// list is in progress; the block itself does not enforce this.
// The block emits one result transaction per selected channel, each valid for
// exactly one cycle while result_strobe is high; the last one has is_last set.
// A list that yields no channel produces a single result with no_channel set.
// The front accepts a list, counts the mask one byte at a time and then
// pushes the list into the queue, waiting there while the queue is full.
// The back loads a list from the queue and then scans the mask one bit per
// cycle from bit 0, stopping after the last selected bit; the highest bit that
// can be selected is bit 58. Results are not always in consecutive cycles.
// A two-entry queue lets the front take the next list while the back still
// emits the previous one.
// Reset clears the queue and both control sequencers and loads the register
// defaults. The receiver cannot stall, so results are never held.
module wlan_scan_channel_list_decode_unit import wscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] band_code,
  input  logic [63:0] channel_bitmap,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_strobe,
  output logic [7:0]  channel,
  output logic [12:0] channel_mhz,
  output logic        is_last,
  output logic        no_channel,
  output logic        list_valid,
  output logic        all_channels,
  output logic [5:0]  channel_count,
  output logic [12:0] first_mhz,
  output logic [15:0] first_chan_field,
  output logic [63:0] normalized_list,
  output logic        rows_moved
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_a_first  <= 1'b1;
      cfg.code_band_24 <= 16'd1;
      cfg.code_band_5  <= 16'd2;
      cfg.code_band_6  <= 16'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_A_FIRST:  cfg.row_a_first  <= cfg_data[0];
        REG_CODE_BAND_24: cfg.code_band_24 <= cfg_data;
        REG_CODE_BAND_5:  cfg.code_band_5  <= cfg_data;
        REG_CODE_BAND_6:  cfg.code_band_6  <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  wscd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .start          (start),
    .busy           (busy),
    .band_code      (band_code),
    .channel_bitmap (channel_bitmap),
    .push           (push),
    .push_item      (push_item),
    .full           (q_full)
  );

  wscd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  wscd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .pop              (pop),
    .result_strobe    (result_strobe),
    .channel          (channel),
    .channel_mhz      (channel_mhz),
    .is_last          (is_last),
    .no_channel       (no_channel),
    .list_valid       (list_valid),
    .all_channels     (all_channels),
    .channel_count    (channel_count),
    .first_mhz        (first_mhz),
    .first_chan_field (first_chan_field),
    .normalized_list  (normalized_list),
    .rows_moved       (rows_moved)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("Queue read while empty.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Front did not go busy after accepting a transaction.");

  a_no_channel_form: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && no_channel) |->
      (is_last && channel_count == 6'd0 && channel == 8'd0 && channel_mhz == 13'd0))
    else $error("Malformed no-channel result.");

endmodule

[test/wlan_scan_channel_list_decode_unit_test.sv]
module wlan_scan_channel_list_decode_unit_test;
  import wscd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    logic [15:0] band;
    logic [63:0] bits;
  } scan_cmd_t;

  typedef struct {
    logic [7:0]  channel;
    logic [12:0] mhz;
    logic        last;
    logic        none;
    logic        valid;
    logic        all;
    logic [5:0]  count;
    logic [12:0] fmhz;
    logic [15:0] ffield;
    logic [63:0] norm;
    logic        moved;
  } chan_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] band_code;
  logic [63:0] channel_bitmap;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        result_strobe;
  logic [7:0]  channel;
  logic [12:0] channel_mhz;
  logic        is_last;
  logic        no_channel;
  logic        list_valid;
  logic        all_channels;
  logic [5:0]  channel_count;
  logic [12:0] first_mhz;
  logic [15:0] first_chan_field;
  logic [63:0] normalized_list;
  logic        rows_moved;

  logic        cfg_row_a_first;
  logic [15:0] cfg_code_24;
  logic [15:0] cfg_code_5;
  logic [15:0] cfg_code_6;

  scan_cmd_t    cmd_q[$];
  scan_cmd_t    next_cmd;
  chan_result_t pending_chans[$];
  chan_result_t want_chan;

  int lists_queued;
  int lists_driven;
  int lists_taken;
  int idle_left;
  int mismatches;
  int cycles;
  bit no_gaps;

  wlan_scan_channel_list_decode_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic band_kind_t kind_of_band(logic [15:0] band);
    if (band == cfg_code_24) return KIND_24;
    if (band == cfg_code_5) return KIND_5;
    if (band == cfg_code_6) return KIND_6;
    return KIND_NONE;
  endfunction

  function automatic logic [7:0] chan_of_bit(band_kind_t kind, bit row_b, int unsigned pos);
    int unsigned c;
    c = 0;
    case (kind)
      KIND_24: begin
        if (!row_b && pos < 14) c = pos + 1;
      end
      KIND_5: begin
        if (!row_b) begin
          if (pos < 8) c = 36 + 4 * pos;
          else if (pos < 20) c = 100 + 4 * (pos - 8);
          else if (pos < 25) c = 149 + 4 * (pos - 20);
        end
      end
      KIND_6: begin
        if (!row_b) c = 1 + 4 * pos;
        else if (pos < 27) c = 129 + 4 * pos;
      end
      default: c = 0;
    endcase
    return c[7:0];
  endfunction

  function automatic logic [12:0] mhz_of(band_kind_t kind, logic [7:0] ch);
    int unsigned f;
    f = 0;
    case (kind)
      KIND_24: f = (ch == 8'd14) ? 2484 : 2407 + 5 * ch;
      KIND_5:  f = 5000 + 5 * ch;
      KIND_6:  f = 5950 + 5 * ch;
      default: f = 0;
    endcase
    return f[12:0];
  endfunction

  function automatic logic [63:0] pack_rows(logic [31:0] a, logic [31:0] b);
    return cfg_row_a_first ? {a, b} : {b, a};
  endfunction

  // Works out every channel result that one list produces and queues them in order.
  function automatic void decode_channel_list(logic [15:0] band, logic [63:0] bits);
    band_kind_t   kind;
    logic [31:0]  wa;
    logic [31:0]  wb;
    logic [31:0]  w;
    logic [7:0]   found [0:63];
    logic [7:0]   ch;
    int           n;
    int           nrows;
    int           row;
    int           pos;
    int           k;
    int           total;
    bit           valid;
    bit           empty;
    bit           moved;
    logic [63:0]  norm;
    logic [12:0]  fmhz;
    logic [15:0]  ffield;
    chan_result_t r;
    kind = kind_of_band(band);
    wa = cfg_row_a_first ? bits[63:32] : bits[31:0];
    wb = cfg_row_a_first ? bits[31:0] : bits[63:32];
    empty = (bits == 64'd0);
    nrows = (kind == KIND_6) ? 2 : 1;
    n = 0;
    if (kind == KIND_NONE) begin
      valid = empty;
    end else begin
      valid = !(kind != KIND_6 && wb != 32'd0);
      for (row = 0; row < nrows; row++) begin
        w = (row == 0) ? wa : wb;
        for (pos = 0; pos < 32; pos++) begin
          ch = chan_of_bit(kind, row != 0, pos);
          if (w[pos] && ch == 8'd0) valid = 1'b0;
          if (ch != 8'd0 && (empty || w[pos])) begin
            found[n] = ch;
            n++;
          end
        end
      end
    end
    fmhz = 13'd0;
    ffield = 16'd0;
    if (kind != KIND_NONE && !empty && n > 0) begin
      fmhz = mhz_of(kind, found[0]);
      ffield = {band[7:0], found[0]};
    end
    moved = 1'b0;
    norm = bits;
    if ((kind == KIND_24 || kind == KIND_5) && wa == 32'd0 && wb != 32'd0) begin
      moved = 1'b1;
      norm = cfg_row_a_first ? {wb, 32'd0} : {32'd0, wb};
    end
    total = (n == 0) ? 1 : n;
    for (k = 0; k < total; k++) begin
      r.channel = (n == 0) ? 8'd0 : found[k];
      r.mhz = (n == 0) ? 13'd0 : mhz_of(kind, found[k]);
      r.last = (k == total - 1);
      r.none = (n == 0);
      r.valid = valid;
      r.all = empty;
      r.count = n[5:0];
      r.fmhz = fmhz;
      r.ffield = ffield;
      r.norm = norm;
      r.moved = moved;
      pending_chans.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 100)
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ROW_A_FIRST:  cfg_row_a_first = data[0];
      REG_CODE_BAND_24: cfg_code_24 = data;
      REG_CODE_BAND_5:  cfg_code_5 = data;
      REG_CODE_BAND_6:  cfg_code_6 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_list(logic [15:0] band, logic [63:0] bits);
    cmd_q.push_back('{band, bits});
    lists_queued++;
  endtask

  // Mostly lists that select real channels of the chosen band, plus empty
  // lists, row B only lists, single bits and raw noise.
  task automatic push_random(int count);
    logic [15:0] band;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] bits;
    band_kind_t  kind;
    int          shape;
    repeat (count) begin
      case ($urandom_range(0, 6))
        0:       band = 16'($urandom);
        1, 2:    band = cfg_code_24;
        3, 4:    band = cfg_code_5;
        default: band = cfg_code_6;
      endcase
      kind = kind_of_band(band);
      ma = (kind == KIND_24) ? MASK_A_24 : (kind == KIND_5) ? MASK_A_5 : MASK_A_6;
      mb = (kind == KIND_6) ? MASK_B_6 : 32'd0;
      shape = $urandom_range(0, 11);
      if (shape == 0) bits = 64'd0;
      else if (shape <= 2) bits = {$urandom, $urandom};
      else if (shape == 3) bits = pack_rows(32'd0, $urandom & $urandom);
      else if (shape == 4) bits = 64'd1 << $urandom_range(0, 63);
      else if (shape <= 7) bits = pack_rows($urandom & $urandom & ma, $urandom & $urandom & mb);
      else bits = pack_rows($urandom & ma, $urandom & mb);
      push_list(band, bits);
    end
  endtask

  task automatic drain();
    while (!(lists_taken == lists_queued && pending_chans.size() == 0 && !busy))
      @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && lists_taken != lists_driven)) begin
      if (idle_left != 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (cmd_q.size() != 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        idle_left = $urandom_range(0, 12);
      end else if (cmd_q.size() != 0) begin
        next_cmd = cmd_q.pop_front();
        band_code <= next_cmd.band;
        channel_bitmap <= next_cmd.bits;
        start <= 1'b1;
        lists_driven++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      if (result_strobe) begin
        if (pending_chans.size() == 0) begin
          report_mismatch("unexpected result, channel", 64'(channel), 64'd0);
        end else begin
          want_chan = pending_chans.pop_front();
          if (channel !== want_chan.channel)
            report_mismatch("channel", 64'(channel), 64'(want_chan.channel));
          if (channel_mhz !== want_chan.mhz)
            report_mismatch("channel_mhz", 64'(channel_mhz), 64'(want_chan.mhz));
          if (is_last !== want_chan.last)
            report_mismatch("is_last", 64'(is_last), 64'(want_chan.last));
          if (no_channel !== want_chan.none)
            report_mismatch("no_channel", 64'(no_channel), 64'(want_chan.none));
          if (list_valid !== want_chan.valid)
            report_mismatch("list_valid", 64'(list_valid), 64'(want_chan.valid));
          if (all_channels !== want_chan.all)
            report_mismatch("all_channels", 64'(all_channels), 64'(want_chan.all));
          if (channel_count !== want_chan.count)
            report_mismatch("channel_count", 64'(channel_count), 64'(want_chan.count));
          if (first_mhz !== want_chan.fmhz)
            report_mismatch("first_mhz", 64'(first_mhz), 64'(want_chan.fmhz));
          if (first_chan_field !== want_chan.ffield)
            report_mismatch("first_chan_field", 64'(first_chan_field),
                            64'(want_chan.ffield));
          if (normalized_list !== want_chan.norm)
            report_mismatch("normalized_list", normalized_list, want_chan.norm);
          if (rows_moved !== want_chan.moved)
            report_mismatch("rows_moved", 64'(rows_moved), 64'(want_chan.moved));
        end
      end
      if (start && !busy) begin
        decode_channel_list(band_code, channel_bitmap);
        lists_taken++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    band_code = 16'd0;
    channel_bitmap = 64'd0;
    cfg_write = 1'b0;
    cfg_index = REG_ROW_A_FIRST;
    cfg_data = 16'd0;
    cfg_row_a_first = 1'b1;
    cfg_code_24 = 16'd1;
    cfg_code_5 = 16'd2;
    cfg_code_6 = 16'd3;
    lists_queued = 0;
    lists_driven = 0;
    lists_taken = 0;
    idle_left = 0;
    mismatches = 0;
    cycles = 0;
    no_gaps = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: row A in the upper half, band codes 1, 2 and 3.
    push_list(16'd1, 64'd0);
    push_list(16'd2, 64'd0);
    push_list(16'd3, 64'd0);
    push_list(16'd0, 64'd0);
    push_list(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_list(16'd1, {32'h0000_3FFF, 32'd0});
    push_list(16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_list(16'd1, {32'd0, 32'h0000_2001});
    push_list(16'd1, {32'h0000_2000, 32'd0});
    push_list(16'd1, {32'h0000_0001, 32'd0});
    push_list(16'd2, {32'h01FF_FFFF, 32'd0});
    push_list(16'd2, {32'hFE00_0000, 32'd0});
    push_list(16'd2, {32'h0010_0180, 32'd0});
    push_list(16'd2, {32'h0108_0000, 32'd0});
    push_list(16'd2, {32'd0, 32'h0000_0001});
    push_list(16'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    push_list(16'd3, {32'd0, 32'h07FF_FFFF});
    push_list(16'd3, {32'h8000_0000, 32'h0400_0000});
    push_list(16'd3, {32'd0, 32'hF800_0000});
    push_list(16'd3, {32'h0000_0001, 32'd0});
    push_list(16'h1234, {32'h0000_0001, 32'd0});
    push_random(40);
    drain();

    write_reg(REG_ROW_A_FIRST, 16'h0000);
    write_reg(REG_CODE_BAND_24, 16'hFFFF);
    write_reg(REG_CODE_BAND_5, 16'h0000);
    write_reg(REG_CODE_BAND_6, 16'h8001);
    push_list(16'hFFFF, 64'd0);
    push_list(16'hFFFF, {32'h0000_0001, 32'd0});
    push_list(16'h0000, {32'd0, 32'h01FF_FFFF});
    push_list(16'h8001, 64'hFFFF_FFFF_FFFF_FFFF);
    push_random(40);
    drain();

    // All three band codes equal, then only 5 GHz and 6 GHz equal.
    write_reg(REG_ROW_A_FIRST, 16'hFFFF);
    write_reg(REG_CODE_BAND_24, 16'h00AB);
    write_reg(REG_CODE_BAND_5, 16'h00AB);
    write_reg(REG_CODE_BAND_6, 16'h00AB);
    push_random(30);
    drain();
    write_reg(REG_CODE_BAND_24, 16'h1234);
    write_reg(REG_CODE_BAND_5, 16'h5A5A);
    write_reg(REG_CODE_BAND_6, 16'h5A5A);
    push_random(30);
    drain();

    write_reg(REG_ROW_A_FIRST, 16'($urandom));
    write_reg(REG_CODE_BAND_24, 16'($urandom));
    write_reg(REG_CODE_BAND_5, 16'($urandom));
    write_reg(REG_CODE_BAND_6, 16'($urandom));
    push_random(50);
    drain();
    no_gaps = 1'b1;
    push_random(40);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
